// ----- hw/rtl/skl_pkg.sv -----
// Shared types, codes and command/status structs for the sorted key list.
// No dependencies; imported by every module of the block.
package skl_pkg;

  localparam int SKL_DEPTH = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] key;
    logic [15:0] handle;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_key;
    logic [15:0] entry_handle;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] handle;
  } entry_t;

  // read address: one below, at, or one above the index
  typedef enum logic [1:0] {RA_DEC, RA_IDX, RA_INC} ra_sel_t;
  // write data: new entry from the item, or the entry just read
  typedef enum logic {WD_NEW, WD_READ} wd_sel_t;
  // result source
  typedef enum logic [2:0] {EM_ITEM, EM_MISS, EM_HOLD, EM_READ, EM_ZERO} em_sel_t;

  typedef struct packed {
    logic       load;
    logic       rd;
    ra_sel_t    ra;
    logic       wr;
    wd_sel_t    wd;
    logic       idx_inc;
    logic       idx_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       hold;
    logic       emit;
    em_sel_t    em;
    logic [1:0] em_status;
    logic       em_last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_end;
    logic idx_last;
    logic rd_ge;
    logic rd_eq;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/sorted_key_list.sv -----
// Top level of the sorted key list: joins controller and datapath.
// Depends on skl_pkg, skl_ctrl and skl_datapath.
//
//   channel  | direction | payload  | handshake
//   in_      | input     | item_t   | in_valid / in_stall
//   out_     | output    | result_t | out_valid / out_stall
//
// One item at a time. Each memory step is a read, then a compare or a
// write back. Insert shifts larger entries up, remove searches for the key
// and shifts the entries above it down, list emits one result per entry.
// Reset clears the fill count, index and result valid; the memory is not
// cleared. A stalled result holds its register and the next step waits.
module sorted_key_list import skl_pkg::*; #(
  parameter int DEPTH = SKL_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  item_t   in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  skl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/skl_datapath.sv -----
// Datapath of the sorted key list: entry memory, index and fill count,
// item latch and result register. Depends on skl_pkg; driven by skl_ctrl.
module skl_datapath import skl_pkg::*; #(
  parameter int DEPTH = SKL_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  item_t    in_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         mem_r [DEPTH];
  entry_t         rdata_r;
  entry_t         hold_r;
  item_t          item_r;
  logic [CW-1:0]  idx_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  idx_p1;
  logic [CW-1:0]  idx_m1;
  logic [AW-1:0]  raddr;
  entry_t         wdata;
  logic           out_valid_r;
  result_t        out_data_r;
  result_t        res_nxt;

  assign idx_p1 = idx_r + CW'(1);
  assign idx_m1 = idx_r - CW'(1);

  always_comb begin
    case (cmd.ra)
      RA_DEC:  raddr = idx_m1[AW-1:0];
      RA_INC:  raddr = idx_p1[AW-1:0];
      default: raddr = idx_r[AW-1:0];
    endcase
  end

  assign wdata = (cmd.wd == WD_NEW) ? entry_t'{key: item_r.key, handle: item_r.handle}
                                    : rdata_r;

  always_comb begin
    res_nxt.status = cmd.em_status;
    res_nxt.last   = cmd.em_last;
    case (cmd.em)
      EM_ITEM: begin
        res_nxt.entry_key    = item_r.key;
        res_nxt.entry_handle = item_r.handle;
      end
      EM_MISS: begin
        res_nxt.entry_key    = item_r.key;
        res_nxt.entry_handle = '0;
      end
      EM_HOLD: begin
        res_nxt.entry_key    = hold_r.key;
        res_nxt.entry_handle = hold_r.handle;
      end
      EM_READ: begin
        res_nxt.entry_key    = rdata_r.key;
        res_nxt.entry_handle = rdata_r.handle;
      end
      default: begin
        res_nxt.entry_key    = '0;
        res_nxt.entry_handle = '0;
      end
    endcase
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[idx_r[AW-1:0]] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem_r[raddr];
    end
    if (cmd.hold) begin
      hold_r <= rdata_r;
    end
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.emit) begin
      out_data_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        // insert walks down from the top, the others walk up from zero
        idx_r <= (in_data.operation == OP_INSERT) ? count_r : '0;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_m1;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_p1;
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.full     = (count_r == CW'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_end  = (idx_r == count_r);
  assign stat.idx_last = (idx_p1 == count_r);
  assign stat.rd_ge    = (rdata_r.key >= item_r.key);
  assign stat.rd_eq    = (rdata_r.key == item_r.key);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/skl_ctrl.sv -----
// Controller of the sorted key list: sequences search, shift and result
// steps for each item. Depends on skl_pkg; commands skl_datapath.
module skl_ctrl import skl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_op,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_STEP, S_INS_CHK, S_INS_DONE, S_INS_FULL,
    S_REM_RD, S_REM_CHK, S_REM_SH_RD, S_REM_SH_WR, S_REM_DONE, S_REM_NONE,
    S_LST_RD, S_LST_OUT, S_LST_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_INSERT: state_nxt = S_INS_STEP;
            OP_REMOVE: state_nxt = S_REM_RD;
            OP_LIST:   state_nxt = S_LST_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_STEP: begin
        if (stat.full) begin
          state_nxt = S_INS_FULL;
        end else if (stat.idx_zero) begin
          cmd.wr      = 1'b1;
          cmd.wd      = WD_NEW;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_INS_DONE;
        end else begin
          cmd.rd    = 1'b1;
          cmd.ra    = RA_DEC;
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        cmd.wr = 1'b1;
        if (stat.rd_ge) begin
          // move the larger entry up one slot and keep walking down
          cmd.wd      = WD_READ;
          cmd.idx_dec = 1'b1;
          state_nxt   = S_INS_STEP;
        end else begin
          cmd.wd      = WD_NEW;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_INS_DONE;
        end
      end
      S_INS_DONE, S_INS_FULL: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.em        = EM_ITEM;
          cmd.em_status = (state_r == S_INS_FULL) ? ST_FULL : ST_OK;
          cmd.em_last   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REM_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_REM_NONE;
        end else begin
          cmd.rd    = 1'b1;
          cmd.ra    = RA_IDX;
          state_nxt = S_REM_CHK;
        end
      end
      S_REM_CHK: begin
        if (stat.rd_eq) begin
          cmd.hold  = 1'b1;
          state_nxt = S_REM_SH_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_REM_RD;
        end
      end
      S_REM_SH_RD: begin
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_REM_DONE;
        end else begin
          cmd.rd    = 1'b1;
          cmd.ra    = RA_INC;
          state_nxt = S_REM_SH_WR;
        end
      end
      S_REM_SH_WR: begin
        cmd.wr      = 1'b1;
        cmd.wd      = WD_READ;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_REM_SH_RD;
      end
      S_REM_DONE, S_REM_NONE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.em        = (state_r == S_REM_DONE) ? EM_HOLD : EM_MISS;
          cmd.em_status = (state_r == S_REM_DONE) ? ST_OK : ST_NOT_FOUND;
          cmd.em_last   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LST_RD: begin
        if (stat.empty) begin
          state_nxt = S_LST_EMPTY;
        end else begin
          cmd.rd    = 1'b1;
          cmd.ra    = RA_IDX;
          state_nxt = S_LST_OUT;
        end
      end
      S_LST_OUT: begin
        // hold the read entry until the result register frees up
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.em        = EM_READ;
          cmd.em_status = ST_OK;
          cmd.em_last   = stat.idx_last;
          cmd.idx_inc   = !stat.idx_last;
          state_nxt     = stat.idx_last ? S_IDLE : S_LST_RD;
        end
      end
      S_LST_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.em        = EM_ZERO;
          cmd.em_status = ST_EMPTY;
          cmd.em_last   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sorted key list: directed and random items,
// random idling on both channels, results checked against an ordered table.
// Depends on skl_pkg and sorted_key_list.
`timescale 1ns / 100ps

module tb_top;
  import skl_pkg::*;

  localparam int DEPTH      = SKL_DEPTH;
  localparam int N_RANDOM   = 250;
  localparam int HOLD_AT    = 100;   // accepted items before the long receiver hold
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_AT   = 130;   // random item that waits for an empty pipeline
  localparam int QUIET_SPAN = 160;   // quiet window with no random idling on either channel
  localparam int TAIL       = 200;

  typedef struct {
    item_t it;
    bit    wait_idle;
  } pending_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  item_t   in_data;
  logic    out_valid;
  logic    out_stall;
  result_t out_data;

  pending_t    pending_q[$];
  result_t     expected_q[$];

  // ordered table as the block should hold it
  logic [15:0] tbl_key[DEPTH];
  logic [15:0] tbl_handle[DEPTH];
  int          tbl_count = 0;

  bit rst_seen = 1'b0;
  bit in_took  = 1'b0;
  bit long_hold_done = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int cyc = 0;
  int errors = 0;
  int n_items = 0, n_results = 0, n_lists = 0, n_full = 0, n_miss = 0, peak = 0;

  sorted_key_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom_range(0, 15));
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h8000;
        default: return 16'h7FFF;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Work out the results of one accepted item and update the table.
  task automatic predict_results(input item_t it);
    result_t r;
    int      pos;
    r = '0;
    r.last = 1'b1;
    pos = 0;
    case (it.operation)
      OP_INSERT: begin
        r.entry_key = it.key;
        r.entry_handle = it.handle;
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          while (pos < tbl_count && tbl_key[pos] < it.key) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_handle[i] = tbl_handle[i-1];
          end
          tbl_key[pos] = it.key;
          tbl_handle[pos] = it.handle;
          tbl_count++;
          if (tbl_count > peak) peak = tbl_count;
          r.status = ST_OK;
        end
        expected_q.push_back(r);
      end
      OP_REMOVE: begin
        while (pos < tbl_count && tbl_key[pos] != it.key) pos++;
        if (pos >= tbl_count) begin
          r.status = ST_NOT_FOUND;
          r.entry_key = it.key;
          n_miss++;
        end else begin
          r.status = ST_OK;
          r.entry_key = tbl_key[pos];
          r.entry_handle = tbl_handle[pos];
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_handle[i] = tbl_handle[i+1];
          end
          tbl_count--;
        end
        expected_q.push_back(r);
      end
      OP_LIST: begin
        n_lists++;
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
          expected_q.push_back(r);
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            r.status = ST_OK;
            r.entry_key = tbl_key[i];
            r.entry_handle = tbl_handle[i];
            r.last = (i + 1 == tbl_count);
            expected_q.push_back(r);
          end
        end
      end
      default: ;  // no result, table untouched
    endcase
  endtask

  function automatic void cmp_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: got %0h", $time, got);
      errors++;
    end else begin
      want = expected_q.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("entry_key", want.entry_key, got.entry_key);
      cmp_field("entry_handle", want.entry_handle, got.entry_handle);
      cmp_field("last", want.last, got.last);
    end
    n_results++;
  endtask

  // Monitor: sample both handshakes at the rising edge.
  always @(posedge clk) begin
    rst_seen = rst_n;
    cyc++;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        n_items++;
        predict_results(in_data);
      end
      if (out_valid && !out_stall) check_result(out_data);
    end
  end

  // Driver: offer the next item at the falling edge once the last one is taken.
  always @(negedge clk) begin
    if (rst_seen && (!in_valid || in_took)) begin
      in_took = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].wait_idle && expected_q.size() != 0)) begin
        in_data <= pending_q[0].it;
        in_valid <= 1'b1;
        void'(pending_q.pop_front());
        send_gap = ((cyc % 1024) < QUIET_SPAN) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold to back the block up.
  always @(negedge clk) begin
    if (!long_hold_done && n_items >= HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((cyc % 1024) < QUIET_SPAN) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  logic [15:0] live_keys[$];

  task automatic add_item(input logic [1:0] op, input logic [15:0] key,
                          input logic [15:0] handle, input bit wait_idle = 1'b0);
    pending_t p;
    int       hit[$];
    p.it.operation = op;
    p.it.key = key;
    p.it.handle = handle;
    p.wait_idle = wait_idle;
    pending_q.push_back(p);
    // track occupancy so the random part can steer towards full and empty
    if (op == OP_INSERT && live_keys.size() < DEPTH) live_keys.push_back(key);
    if (op == OP_REMOVE) begin
      hit = live_keys.find_first_index(k) with (k == key);
      if (hit.size() != 0) live_keys.delete(hit[0]);
    end
  endtask

  initial begin
    int          n_rand;
    int          r;
    int          full_tries;
    bit          filling;
    logic [1:0]  op;
    logic [15:0] key;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;

    // directed: empty table, ordering of equal keys, removal at both ends
    add_item(OP_LIST,   16'h0000, 16'h0000);
    add_item(OP_REMOVE, 16'h1234, 16'h0000);
    add_item(OP_NONE,   16'hFFFF, 16'hFFFF);
    add_item(OP_INSERT, 16'h8000, 16'h0001);
    add_item(OP_INSERT, 16'hFFFF, 16'hFFFF);
    add_item(OP_INSERT, 16'h0000, 16'h0000);
    add_item(OP_INSERT, 16'h8000, 16'h5555);
    add_item(OP_INSERT, 16'h7FFF, 16'hAAAA);
    add_item(OP_LIST,   16'h0000, 16'h0000);
    add_item(OP_REMOVE, 16'h8000, 16'h0000);
    add_item(OP_REMOVE, 16'h1234, 16'hFFFF);
    add_item(OP_REMOVE, 16'hFFFF, 16'h0000);
    add_item(OP_REMOVE, 16'h0000, 16'h0000);
    add_item(OP_LIST,   16'hFFFF, 16'hFFFF);
    add_item(OP_NONE,   16'h0000, 16'h0000);
    add_item(OP_REMOVE, 16'h8000, 16'h0000);
    add_item(OP_REMOVE, 16'h7FFF, 16'h0000);
    add_item(OP_LIST,   16'h0000, 16'h0000);

    // random: alternate fill and drain spells so full and empty are both reached
    n_rand = 0;
    full_tries = 0;
    filling = 1'b1;
    while (n_rand < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_NONE;
      else if (filling) op = (r < 70) ? OP_INSERT : (r < 85) ? OP_REMOVE : OP_LIST;
      else op = (r < 20) ? OP_INSERT : (r < 80) ? OP_REMOVE : OP_LIST;
      key = pick_key();
      if (op == OP_REMOVE && live_keys.size() != 0 && $urandom_range(0, 2) != 0)
        key = live_keys[$urandom_range(0, live_keys.size() - 1)];
      if (op == OP_INSERT && live_keys.size() == DEPTH) full_tries++;
      add_item(op, key, 16'($urandom_range(0, 65535)), n_rand == DRAIN_AT);
      if (op != OP_NONE) n_rand++;
      if (filling && full_tries >= 2) begin
        filling = 1'b0;
        full_tries = 0;
      end else if (!filling && live_keys.size() == 0) begin
        filling = 1'b1;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Covered %0d items and %0d results: %0d lists, %0d full rejections,",
             n_items, n_results, n_lists, n_full);
    $display("%0d removes of absent keys, table peaked at %0d entries.", n_miss, peak);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[sorted_key_list] OK");
    end else begin
      $display("[sorted_key_list] ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
    $display("[sorted_key_list] ERROR");
    $finish;
  end

endmodule
